@@ src/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and widths of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int unsigned MAP_BITS_DEF  = 32768;
    localparam int unsigned WORD_BITS_DEF = 32;

    localparam int unsigned BLK_W      = 15;
    localparam int unsigned LIM_W      = 16;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned ST_W       = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept_alloc;
        logic accept_free;
        logic fail_now;
        logic scan_run;
        logic free_check;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_empty;
        logic scan_hit;
        logic scan_miss;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ src/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller of the allocator: clear pass, request dispatch and scan control.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_mode,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_FREE) begin
                        n_state = S_FREE;
                    end else if (!i_stat.scan_empty) begin
                        n_state = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (i_stat.scan_hit || i_stat.scan_miss) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_mode == MODE_FREE) begin
                        o_cmd.accept_free = 1'b1;
                    end else if (i_stat.scan_empty) begin
                        o_cmd.fail_now = 1'b1;
                    end else begin
                        o_cmd.accept_alloc = 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                o_cmd.scan_run = 1'b1;
            end
            S_FREE: begin
                o_cmd.free_check = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

@@ src/bba_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory, configuration registers, word scan, free counter and
// result registers of the allocator.
// ----------------------------------------------------------------------------
module bba_datapath
    import bba_pkg::*;
#(
    parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic [BLK_W-1:0]      i_block_number,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_done,
    output logic [BLK_W-1:0]           o_granted_block,
    output logic [ST_W-1:0]            o_status,
    output logic [CNT_W-1:0]           o_free_remaining
);

    localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned SH        = $clog2(WORD_BITS);
    localparam int unsigned WI_W      = LIM_W - SH;
    localparam int unsigned MAP_CAP   = (MAP_BITS > 65535) ? 65535 : MAP_BITS;
    localparam logic [LIM_W-1:0] MAP_LIM = LIM_W'(MAP_CAP);
    localparam logic [SH-1:0]    OFF_MAX = SH'(WORD_BITS - 1);
    localparam logic [AW-1:0]    CLR_LAST = AW'(MAP_WORDS - 1);

    function automatic logic [AW-1:0] to_addr(input logic [WI_W-1:0] w);
        logic [31:0] t;
        t = 32'(w);
        return t[AW-1:0];
    endfunction

    // configuration
    logic [BLK_W-1:0] r_first;
    logic [LIM_W-1:0] r_limit;
    logic [CNT_W-1:0] r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= BLK_W'(1);
            r_limit <= LIM_W'(32768);
            r_init  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_FIRST) begin
                r_first <= i_cfg_data[BLK_W-1:0];
            end
            if (i_cfg_addr == CFG_LIMIT) begin
                r_limit <= i_cfg_data[LIM_W-1:0];
            end
            if (i_cfg_addr == CFG_INIT) begin
                r_init <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] lim_m1;
    logic [LIM_W-1:0] first16;
    logic [WI_W-1:0]  first_word;
    logic [WI_W-1:0]  last_word;
    logic [SH-1:0]    first_off;
    logic [SH-1:0]    last_off;

    assign lim        = (r_limit > MAP_LIM) ? MAP_LIM : r_limit;
    assign lim_m1     = lim - LIM_W'(1);
    assign first16    = {1'b0, r_first};
    assign first_word = first16[LIM_W-1:SH];
    assign first_off  = first16[SH-1:0];
    assign last_word  = lim_m1[LIM_W-1:SH];
    assign last_off   = lim_m1[SH-1:0];

    // bitmap memory
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [AW-1:0]        mem_raddr;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_we;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // clear pass
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // request latch
    logic [LIM_W-1:0] r_blk;
    logic [LIM_W-1:0] in_blk;

    assign in_blk = {1'b0, i_block_number};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_free) begin
            r_blk <= in_blk;
        end
    end

    // word scan
    logic [WI_W-1:0] r_iss_word;
    logic            r_iss_more;
    logic [WI_W-1:0] r_chk_word;
    logic            r_chk_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_more <= 1'b0;
            r_chk_v    <= 1'b0;
        end else if (i_cmd.accept_alloc) begin
            r_iss_word <= first_word;
            r_iss_more <= 1'b1;
            r_chk_v    <= 1'b0;
        end else if (i_cmd.scan_run && r_iss_more) begin
            r_iss_word <= r_iss_word + WI_W'(1);
            r_iss_more <= (r_iss_word != last_word);
            r_chk_word <= r_iss_word;
            r_chk_v    <= 1'b1;
        end else begin
            r_chk_v    <= 1'b0;
        end
    end

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] cand;
    logic [SH-1:0]        pos;
    logic                 found;
    logic [LIM_W-1:0]     grant16;

    always_comb begin
        lo_mask = (r_chk_word == first_word) ? ({WORD_BITS{1'b1}} << first_off)
                                             : {WORD_BITS{1'b1}};
        hi_mask = (r_chk_word == last_word) ? ({WORD_BITS{1'b1}} >> (OFF_MAX - last_off))
                                            : {WORD_BITS{1'b1}};
        cand    = ~r_rd_data & lo_mask & hi_mask;
        found   = |cand;
        pos     = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (cand[p]) begin
                pos = SH'(p);
            end
        end
    end

    assign grant16 = {r_chk_word, pos};

    logic scan_hit;
    logic scan_miss;
    logic hit_now;
    logic miss_now;

    assign scan_hit  = r_chk_v && found;
    assign scan_miss = r_chk_v && !found && (r_chk_word == last_word);
    assign hit_now   = i_cmd.scan_run && scan_hit;
    assign miss_now  = i_cmd.scan_run && scan_miss;

    // free check
    logic [SH-1:0] free_off;
    logic          free_in_range;
    logic          free_wr;

    assign free_off      = r_blk[SH-1:0];
    assign free_in_range = r_blk < lim;
    assign free_wr       = i_cmd.free_check && free_in_range && r_rd_data[free_off];

    // memory port selection
    always_comb begin
        mem_raddr = i_cmd.accept_free ? to_addr(in_blk[LIM_W-1:SH]) : to_addr(r_iss_word);
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        priority if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
        end else if (hit_now) begin
            mem_we    = 1'b1;
            mem_waddr = to_addr(r_chk_word);
            mem_wdata = r_rd_data | (WORD_BITS'(1) << pos);
        end else if (free_wr) begin
            mem_we    = 1'b1;
            mem_waddr = to_addr(r_blk[LIM_W-1:SH]);
            mem_wdata = r_rd_data & ~(WORD_BITS'(1) << free_off);
        end
    end

    // free counter
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        priority if (i_cfg_we && (i_cfg_addr == CFG_INIT)) begin
            n_count = i_cfg_data[CNT_W-1:0];
        end else if (hit_now && (r_count != '0)) begin
            n_count = r_count - CNT_W'(1);
        end else if (free_wr && (r_count != '1)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result registers
    logic             res_valid;
    logic             r_done;
    logic [BLK_W-1:0] r_granted;
    logic [ST_W-1:0]  r_status;
    logic [CNT_W-1:0] r_free;

    assign res_valid = i_cmd.fail_now || hit_now || miss_now || i_cmd.free_check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_free <= n_count;
            priority if (hit_now) begin
                r_granted <= grant16[BLK_W-1:0];
                r_status  <= ST_OK;
            end else if (i_cmd.free_check) begin
                r_granted <= '0;
                r_status  <= free_in_range ? ST_OK : ST_RANGE;
            end else begin
                r_granted <= '0;
                r_status  <= ST_NO_SPACE;
            end
        end
    end

    assign o_done           = r_done;
    assign o_granted_block  = r_granted;
    assign o_status         = r_status;
    assign o_free_remaining = r_free;

    assign o_stat = '{
        clr_done:   (r_clr_addr == CLR_LAST),
        scan_empty: (first16 >= lim),
        scan_hit:   scan_hit,
        scan_miss:  scan_miss
    };

endmodule
`default_nettype wire

@@ src/bitmap_block_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit bitmap block allocator with a saturating free block counter.
//
// Requests enter on i_start while o_busy is low: i_mode selects allocate or
// free, i_block_number names the block to free. Each request gives exactly
// one result, shown for one cycle with o_done high; the receiver cannot
// stall it.
// A free reads its bitmap word on accept, then checks and clears the bit;
// o_done is registered. An allocate reads the bitmap one word per cycle
// from the word holding first_data_block up to the word holding the last
// allocatable block; the word that decides the result is checked from the
// read register and the result is registered to o_done. An allocate with
// an empty range is answered from the idle state without a scan, with
// o_done in the next cycle. The single read port of the bitmap memory bounds
// the scan at one word a cycle. The configuration port writes the register
// named by i_cfg_addr whenever i_cfg_we is high; index 2 also loads the free
// counter. After reset the bitmap is cleared one word a cycle, o_busy high.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_mode,
    input  wire logic [BLK_W-1:0]      i_block_number,
    output logic                       o_done,
    output logic [BLK_W-1:0]           o_granted_block,
    output logic [ST_W-1:0]            o_status,
    output logic [CNT_W-1:0]           o_free_remaining,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    bba_datapath #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_block_number   (i_block_number),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_granted_block  (o_granted_block),
        .o_status         (o_status),
        .o_free_remaining (o_free_remaining)
    );

endmodule
`default_nettype wire

@@ verif/bitmap_block_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Self-checking bench for the first-fit bitmap block allocator. A local
// model of the bitmap, the registers and the saturating free counter
// predicts every response. Directed items cover reset values, register
// extremes, empty ranges, block zero, range errors, double frees and counter
// saturation. They are followed by random allocate/free traffic over many
// register settings, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb;
    import bba_pkg::*;

    localparam int unsigned MAP_SIZE     = MAP_BITS_DEF;
    localparam int unsigned RANDOM_ITEMS = 555;
    localparam int unsigned TIMEOUT_NS   = 50_000_000;

    typedef struct packed {
        logic [BLK_W-1:0] granted;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] remaining;
    } alloc_result_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_start        = 1'b0;
    logic                  i_mode         = MODE_ALLOC;
    logic [BLK_W-1:0]      i_block_number = '0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr     = CFG_FIRST;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [BLK_W-1:0]      o_granted_block;
    logic [ST_W-1:0]       o_status;
    logic [CNT_W-1:0]      o_free_remaining;

    bit               used_map [MAP_SIZE];
    logic [BLK_W-1:0] cfg_first = 15'd1;
    logic [LIM_W-1:0] cfg_limit = 16'd32768;
    logic [CNT_W-1:0] free_cnt  = 16'd0;

    alloc_result_t    awaited_responses[$];
    logic [BLK_W-1:0] held_blocks[$];
    int unsigned      mismatch_count = 0;
    int unsigned      response_index = 0;

    bitmap_block_allocator_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_mode           (i_mode),
        .i_block_number   (i_block_number),
        .o_done           (o_done),
        .o_granted_block  (o_granted_block),
        .o_status         (o_status),
        .o_free_remaining (o_free_remaining),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic alloc_result_t next_allocation_result(input logic mode,
                                                             input logic [BLK_W-1:0] blk);
        alloc_result_t r;
        int unsigned   lim;
        int unsigned   idx;
        bit            found;
        r     = '{granted: '0, status: ST_OK, remaining: '0};
        lim   = (32'(cfg_limit) > MAP_SIZE) ? MAP_SIZE : 32'(cfg_limit);
        found = 1'b0;
        if (mode == MODE_ALLOC) begin
            idx = 32'(cfg_first);
            while (idx < lim && !found) begin
                if (!used_map[idx]) begin
                    used_map[idx] = 1'b1;
                    r.granted     = idx[BLK_W-1:0];
                    found         = 1'b1;
                end
                idx++;
            end
            if (found) begin
                if (free_cnt != 0)
                    free_cnt = free_cnt - 16'd1;
            end else begin
                r.status = ST_NO_SPACE;
            end
        end else begin
            if (32'(blk) >= lim) begin
                r.status = ST_RANGE;
            end else if (used_map[blk]) begin
                used_map[blk] = 1'b0;
                if (free_cnt != 16'hFFFF)
                    free_cnt = free_cnt + 16'd1;
            end
        end
        r.remaining = free_cnt;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : check_responses
        alloc_result_t want;
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_responses.size() == 0) begin
                note_mismatch($sformatf("unexpected response: granted %0d status %0d remaining %0d",
                                        o_granted_block, o_status, o_free_remaining));
            end else begin
                want = awaited_responses.pop_front();
                if (o_granted_block !== want.granted || o_status !== want.status ||
                    o_free_remaining !== want.remaining)
                    note_mismatch($sformatf({"response %0d: expected granted %0d status %0d ",
                                             "remaining %0d, got granted %0d status %0d ",
                                             "remaining %0d"},
                                            response_index, want.granted, want.status,
                                            want.remaining, o_granted_block, o_status,
                                            o_free_remaining));
            end
            response_index++;
        end
    end

    task automatic issue_request(input logic mode, input logic [BLK_W-1:0] blk);
        alloc_result_t want;
        i_start        <= 1'b1;
        i_mode         <= mode;
        i_block_number <= blk;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        want = next_allocation_result(mode, blk);
        awaited_responses.push_back(want);
        if (mode == MODE_ALLOC && want.status == ST_OK)
            held_blocks.push_back(want.granted);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // hold off until every response is in and the core is idle
    task automatic settle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (awaited_responses.size() != 0 || o_busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FIRST: cfg_first = value[BLK_W-1:0];
            CFG_LIMIT: cfg_limit = value;
            CFG_INIT:  free_cnt  = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_after_reset();
        issue_request(MODE_ALLOC, 15'h7FFF);
        issue_request(MODE_ALLOC, 15'd0);
        issue_request(MODE_FREE, 15'd1);
        issue_request(MODE_FREE, 15'd1);
        issue_request(MODE_FREE, 15'd0);
        issue_request(MODE_FREE, 15'h7FFF);
        issue_request(MODE_ALLOC, 15'h5555);
    endtask

    task automatic test_register_extremes();
        settle();
        write_register(CFG_FIRST, 16'd0);
        write_register(CFG_LIMIT, 16'hFFFF);
        write_register(CFG_INIT, 16'hFFFE);
        issue_request(MODE_ALLOC, 15'h2AAA);
        settle();
        write_register(CFG_INIT, 16'hFFFF);
        issue_request(MODE_FREE, 15'd0);
        issue_request(MODE_FREE, 15'd2);
        settle();
        write_register(CFG_FIRST, 16'd32767);
        write_register(CFG_LIMIT, 16'd32768);
        write_register(CFG_INIT, 16'd2);
        issue_request(MODE_ALLOC, 15'd0);
        issue_request(MODE_ALLOC, 15'd0);
        issue_request(MODE_FREE, 15'd32767);
        settle();
        write_register(CFG_FIRST, 16'd0);
        write_register(CFG_LIMIT, 16'd0);
        issue_request(MODE_ALLOC, 15'd0);
        issue_request(MODE_FREE, 15'd0);
        settle();
        write_register(CFG_FIRST, 16'd40);
        write_register(CFG_LIMIT, 16'd36);
        issue_request(MODE_ALLOC, 15'd0);
        issue_request(MODE_FREE, 15'd36);
        issue_request(MODE_FREE, 15'd35);
    endtask

    task automatic test_exhaustion();
        settle();
        write_register(CFG_FIRST, 16'd100);
        write_register(CFG_LIMIT, 16'd104);
        write_register(CFG_INIT, 16'd4);
        repeat (5) issue_request(MODE_ALLOC, 15'd0);
        issue_request(MODE_FREE, 15'd102);
        issue_request(MODE_ALLOC, 15'd0);
    endtask

    task automatic test_random_traffic();
        int unsigned      sent;
        int unsigned      phase_len;
        int unsigned      burst_left;
        int unsigned      pick;
        int unsigned      roll;
        int unsigned      first_v;
        int unsigned      limit_v;
        int unsigned      init_v;
        logic [BLK_W-1:0] target;
        sent       = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 5))
                0: begin
                    first_v = $urandom_range(0, 32767);
                    limit_v = $urandom_range(0, 65535);
                end
                1: begin
                    first_v = $urandom_range(0, 64);
                    limit_v = first_v + $urandom_range(1, 48);
                end
                2: begin
                    first_v = $urandom_range(32700, 32767);
                    limit_v = $urandom_range(32768, 65535);
                end
                3: begin
                    first_v = $urandom_range(0, 32000);
                    limit_v = first_v + $urandom_range(8, 160);
                end
                4: begin
                    first_v = 0;
                    limit_v = $urandom_range(1, 64);
                end
                default: begin
                    first_v = $urandom_range(0, 32767);
                    limit_v = $urandom_range(0, first_v);
                end
            endcase
            case ($urandom_range(0, 3))
                0: init_v = 0;
                1: init_v = $urandom_range(0, 64);
                2: init_v = 65535 - $urandom_range(0, 3);
                default: init_v = $urandom_range(0, 65535);
            endcase
            write_register(CFG_FIRST, first_v[15:0]);
            write_register(CFG_LIMIT, limit_v[15:0]);
            write_register(CFG_INIT, init_v[15:0]);
            phase_len = $urandom_range(30, 60);
            while (phase_len != 0 && sent < RANDOM_ITEMS) begin
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 12));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 10);
                end
                roll = $urandom_range(0, 99);
                if (roll < 50 || (roll < 85 && held_blocks.size() == 0)) begin
                    issue_request(MODE_ALLOC, BLK_W'($urandom_range(0, 32767)));
                end else if (roll < 85) begin
                    // release a block handed out earlier
                    pick              = $urandom_range(0, held_blocks.size() - 1);
                    target            = held_blocks[pick];
                    held_blocks[pick] = held_blocks[held_blocks.size() - 1];
                    void'(held_blocks.pop_back());
                    issue_request(MODE_FREE, target);
                end else if (roll < 93) begin
                    issue_request(MODE_FREE, BLK_W'($urandom_range(0, 32767)));
                end else begin
                    // blocks at the range boundaries
                    case ($urandom_range(0, 2))
                        0: target = cfg_limit[BLK_W-1:0];
                        1: target = cfg_limit[BLK_W-1:0] - BLK_W'(1);
                        default: target = cfg_first;
                    endcase
                    issue_request(MODE_FREE, target);
                end
                burst_left--;
                phase_len--;
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_register_extremes();
        test_exhaustion();
        test_random_traffic();
        settle();
        if (mismatch_count == 0 && awaited_responses.size() == 0) begin
            $display("** bitmap_block_allocator_core: PASSED **");
        end else begin
            $display("** bitmap_block_allocator_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** bitmap_block_allocator_core: FAILED **");
        $finish;
    end

endmodule
